@@ rtl/core/fpa_pkg.sv @@
// fpa_pkg: shared types, mode codes and saturation helper for the fixed-point alu
// no dependencies; imported by every module of the block except fpa_delay
`default_nettype none
package fpa_pkg;

  localparam int WORD_W            = 32;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_DIV      = 4'd3,
    MODE_GT       = 4'd4,
    MODE_LT       = 4'd5,
    MODE_GE       = 4'd6,
    MODE_LE       = 4'd7,
    MODE_EQ       = 4'd8,
    MODE_NE       = 4'd9,
    MODE_MIN      = 4'd10,
    MODE_MAX      = 4'd11,
    MODE_INC      = 4'd12,
    MODE_DEC      = 4'd13,
    MODE_TO_INT   = 4'd14,
    MODE_FROM_INT = 4'd15
  } mode_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              cmp;
    logic              ovf;
    logic              dz;
  } res_t;

  // signed result from magnitude and sign, clamped to the word range
  function automatic res_t sat_mag(input logic [63:0] mag, input logic neg);
    res_t r;
    r = '0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.ovf   = 1'b1;
        r.value = WORD_MIN;
      end else begin
        r.value = 32'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h0000_0000_7fff_ffff) begin
        r.ovf   = 1'b1;
        r.value = WORD_MAX;
      end else begin
        r.value = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fpa_delay.sv @@
// fpa_delay: enable-gated shift line that aligns side results with the divider
// depends on nothing but its parameters
`default_nettype none
module fpa_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule
`default_nettype wire

@@ rtl/core/fpa_mul.sv @@
// fpa_mul: three-stage fixed-point multiply, product, rounding, saturation
// depends on fpa_pkg
`default_nettype none
module fpa_mul
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [WORD_W-1:0] a_i,
  input  wire logic signed [WORD_W-1:0] b_i,
  output res_t                          res_o
);

  localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  logic signed [63:0] prod_r;
  logic [63:0]        rnd_nxt;
  logic [63:0]        rmag_r;
  logic               neg_r;
  res_t               res_r;

  // |p| + half folded into one add: for negative p it is ~p + half + 1
  always_comb begin
    if (prod_r[63]) begin
      rnd_nxt = ~prod_r + (HALF + 64'd1);
    end else begin
      rnd_nxt = prod_r + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a_i * b_i;
      rmag_r <= rnd_nxt >> FRACTION_BITS;
      neg_r  <= prod_r[63];
      res_r  <= sat_mag(rmag_r, neg_r);
    end
  end

  assign res_o = res_r;

endmodule
`default_nettype wire

@@ rtl/core/fpa_div_stage.sv @@
// fpa_div_stage: one restoring-division step, one quotient bit per stage
// depends on fpa_pkg
`default_nettype none
module fpa_div_stage
  import fpa_pkg::*;
#(
  parameter int NW = 40
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [WORD_W-1:0] rem_i,
  input  wire logic [NW-1:0]     nsh_i,
  input  wire logic [NW-1:0]     q_i,
  input  wire logic [WORD_W-1:0] d_i,
  input  wire logic              neg_i,
  input  wire logic              aneg_i,
  output logic      [WORD_W-1:0] rem_o,
  output logic      [NW-1:0]     nsh_o,
  output logic      [NW-1:0]     q_o,
  output logic      [WORD_W-1:0] d_o,
  output logic                   neg_o,
  output logic                   aneg_o
);

  logic [WORD_W:0] trial;
  logic [WORD_W:0] diff;
  logic            ge;

  always_comb begin
    trial = {rem_i, nsh_i[NW-1]};
    diff  = trial - {1'b0, d_i};
    ge    = trial >= {1'b0, d_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      nsh_o  <= {nsh_i[NW-2:0], 1'b0};
      q_o    <= {q_i[NW-2:0], ge};
      d_o    <= d_i;
      neg_o  <= neg_i;
      aneg_o <= aneg_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fpa_divider.sv @@
// fpa_divider: pipelined rounded fixed-point divide, entry, NW bit stages, round, clamp
// depends on fpa_pkg and fpa_div_stage
`default_nettype none
module fpa_divider
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [WORD_W-1:0] a_i,
  input  wire logic signed [WORD_W-1:0] b_i,
  output res_t                          res_o
);

  localparam int NW = WORD_W + FRACTION_BITS;

  logic [WORD_W-1:0] rem_w  [NW+1];
  logic [NW-1:0]     nsh_w  [NW+1];
  logic [NW-1:0]     q_w    [NW+1];
  logic [WORD_W-1:0] d_w    [NW+1];
  logic              neg_w  [NW+1];
  logic              aneg_w [NW+1];

  logic [WORD_W-1:0] amag;
  logic [WORD_W-1:0] bmag;
  logic [NW:0]       qr_r;
  logic              rneg_r;
  logic              raneg_r;
  logic              rdz_r;
  res_t              res_r;
  res_t              res_nxt;

  assign amag = a_i[WORD_W-1] ? WORD_W'(0 - a_i) : a_i;
  assign bmag = b_i[WORD_W-1] ? WORD_W'(0 - b_i) : b_i;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_w[0]  <= '0;
      nsh_w[0]  <= {amag, {FRACTION_BITS{1'b0}}};
      q_w[0]    <= '0;
      d_w[0]    <= bmag;
      neg_w[0]  <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
      aneg_w[0] <= a_i[WORD_W-1];
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    fpa_div_stage #(.NW(NW)) u_stage (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem_w[i]),
      .nsh_i  (nsh_w[i]),
      .q_i    (q_w[i]),
      .d_i    (d_w[i]),
      .neg_i  (neg_w[i]),
      .aneg_i (aneg_w[i]),
      .rem_o  (rem_w[i+1]),
      .nsh_o  (nsh_w[i+1]),
      .q_o    (q_w[i+1]),
      .d_o    (d_w[i+1]),
      .neg_o  (neg_w[i+1]),
      .aneg_o (aneg_w[i+1])
    );
  end

  // round half away from zero: bump when twice the remainder reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      qr_r    <= {1'b0, q_w[NW]} +
                 (NW+1)'({rem_w[NW], 1'b0} >= {1'b0, d_w[NW]});
      rneg_r  <= neg_w[NW];
      raneg_r <= aneg_w[NW];
      rdz_r   <= d_w[NW] == '0;
    end
  end

  always_comb begin
    if (rdz_r) begin
      res_nxt       = '0;
      res_nxt.dz    = 1'b1;
      res_nxt.value = raneg_r ? WORD_MIN : WORD_MAX;
    end else begin
      res_nxt = sat_mag(64'(qr_r), rneg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule
`default_nettype wire

@@ rtl/core/fixed_point_q24_8_alu.sv @@
// throughput: one transaction per cycle unless the output stalls; the divider resolves one quotient bit per stage
// over 32 + FRACTION_BITS stages, and every other mode is delayed to match
// a stalled output freezes the whole pipeline; in_ready is low only while a result waits
// reset: synchronous active-low rst_n clears all valid bits, data registers are not reset
`default_nettype none
module fixed_point_q24_8_alu
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [3:0]               in_mode,
  input  wire logic signed [WORD_W-1:0] in_operand_a,
  input  wire logic signed [WORD_W-1:0] in_operand_b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [WORD_W-1:0]      out_result_value,
  output logic                          out_compare_true,
  output logic                          out_overflow,
  output logic                          out_divide_by_zero
);

  localparam int NW      = WORD_W + FRACTION_BITS;
  localparam int DIV_LAT = NW + 3;
  localparam int MUL_LAT = 3;
  localparam int RES_W   = $bits(res_t);

  logic                     en;
  logic                     v_r [DIV_LAT+1];
  logic [3:0]               mode_r;
  logic signed [WORD_W-1:0] a_r;
  logic signed [WORD_W-1:0] b_r;

  res_t       simple_nxt;
  res_t       simple_r;
  res_t       simple_d;
  res_t       mul_res;
  res_t       mul_d;
  res_t       div_res;
  logic [3:0] mode_d;
  res_t       out_r;
  res_t       out_nxt;
  logic       out_valid_r;

  logic signed [WORD_W:0] sum33;
  logic signed [WORD_W:0] dif33;
  logic signed [WORD_W:0] inc33;
  logic signed [WORD_W:0] dec33;
  logic signed [63:0]     from64;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  function automatic res_t sat33(input logic signed [WORD_W:0] s);
    res_t r;
    r = '0;
    if (s[WORD_W] != s[WORD_W-1]) begin
      r.ovf   = 1'b1;
      r.value = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r.value = s[WORD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r <= in_mode;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_LAT; i++) begin
        v_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= DIV_LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
      out_valid_r <= v_r[DIV_LAT];
    end
  end

  always_comb begin
    sum33  = {a_r[WORD_W-1], a_r} + {b_r[WORD_W-1], b_r};
    dif33  = {a_r[WORD_W-1], a_r} - {b_r[WORD_W-1], b_r};
    inc33  = {a_r[WORD_W-1], a_r} + 33'sd1;
    dec33  = {a_r[WORD_W-1], a_r} - 33'sd1;
    from64 = 64'(a_r) <<< FRACTION_BITS;
    simple_nxt = '0;
    case (mode_t'(mode_r))
      MODE_ADD: simple_nxt = sat33(sum33);
      MODE_SUB: simple_nxt = sat33(dif33);
      MODE_INC: simple_nxt = sat33(inc33);
      MODE_DEC: simple_nxt = sat33(dec33);
      MODE_GT:  simple_nxt.cmp = a_r > b_r;
      MODE_LT:  simple_nxt.cmp = a_r < b_r;
      MODE_GE:  simple_nxt.cmp = a_r >= b_r;
      MODE_LE:  simple_nxt.cmp = a_r <= b_r;
      MODE_EQ:  simple_nxt.cmp = a_r == b_r;
      MODE_NE:  simple_nxt.cmp = a_r != b_r;
      MODE_MIN: simple_nxt.value = (a_r < b_r) ? a_r : b_r;
      MODE_MAX: simple_nxt.value = (a_r > b_r) ? a_r : b_r;
      MODE_TO_INT: simple_nxt.value = a_r >>> FRACTION_BITS;
      MODE_FROM_INT: begin
        // fits only when the bits above the word are a copy of its sign
        if (&from64[63:WORD_W-1] || ~|from64[63:WORD_W-1]) begin
          simple_nxt.value = from64[WORD_W-1:0];
        end else begin
          simple_nxt.ovf   = 1'b1;
          simple_nxt.value = from64[63] ? WORD_MIN : WORD_MAX;
        end
      end
      default: simple_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      simple_r <= simple_nxt;
    end
  end

  fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .en    (en),
    .a_i   (a_r),
    .b_i   (b_r),
    .res_o (mul_res)
  );

  fpa_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .en    (en),
    .a_i   (a_r),
    .b_i   (b_r),
    .res_o (div_res)
  );

  fpa_delay #(.W(4), .DEPTH(DIV_LAT)) u_mode_dly (
    .clk (clk),
    .en  (en),
    .d_i (mode_r),
    .q_o (mode_d)
  );

  fpa_delay #(.W(RES_W), .DEPTH(DIV_LAT - 1)) u_simple_dly (
    .clk (clk),
    .en  (en),
    .d_i (simple_r),
    .q_o (simple_d)
  );

  fpa_delay #(.W(RES_W), .DEPTH(DIV_LAT - MUL_LAT)) u_mul_dly (
    .clk (clk),
    .en  (en),
    .d_i (mul_res),
    .q_o (mul_d)
  );

  always_comb begin
    case (mode_t'(mode_d))
      MODE_MUL: out_nxt = mul_d;
      MODE_DIV: out_nxt = div_res;
      default:  out_nxt = simple_d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_r.value;
  assign out_compare_true   = out_r.cmp;
  assign out_overflow       = out_r.ovf;
  assign out_divide_by_zero = out_r.dz;

endmodule
`default_nettype wire

@@ rtl/core/fpa_checker.sv @@
// fpa_checker: port-level assertions for the fixed-point alu, bound to the top level
// depends on fpa_pkg and the fixed_point_q24_8_alu port list
`default_nettype none
module fpa_checker
  import fpa_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic [3:0]               in_mode,
  input wire logic signed [WORD_W-1:0] in_operand_a,
  input wire logic signed [WORD_W-1:0] in_operand_b,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [WORD_W-1:0] out_result_value,
  input wire logic                     out_compare_true,
  input wire logic                     out_overflow,
  input wire logic                     out_divide_by_zero
);

  // a stalled result stays valid and keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("output transaction changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a true compare result carries a zero word and no overflow or divide-by-zero flag
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == 0 && !out_overflow
      && !out_divide_by_zero)
    else $error("compare result carries data or flags");

  // divide by zero saturates by sign and never flags overflow
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_overflow
      && (out_result_value == $signed(WORD_MAX) || out_result_value == $signed(WORD_MIN)))
    else $error("divide by zero result malformed");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (.*);
`default_nettype wire
